@@ rtl/core/qrs_pkg.sv @@
// qrs_pkg: shared widths, solution codes and transaction types of the quadratic root solver
// no dependencies; imported by every module under rtl/core
package qrs_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ROOT_WIDTH = 48;
	localparam int THR_W      = 16;
	localparam int MAG_W      = DATA_WIDTH;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int DISC_W     = PROD_W + 2;
	localparam int SQRT_W     = DISC_W / 2;
	localparam int REM_W      = SQRT_W + 3;
	localparam int NUM_W      = SQRT_W + 2;
	localparam int DEN_W      = MAG_W + 1;
	localparam int DVD_W      = NUM_W + FRAC_BITS;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// register index decoded from paddr[2]
	localparam logic REG_ZERO_THRESH = 1'b0;
	localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(1);

	typedef enum logic [1:0] {
		KIND_ANY,
		KIND_NONE,
		KIND_LINEAR,
		KIND_TWO
	} kind_t;

	// classified coefficient set, sign and magnitude
	typedef struct packed {
		kind_t              kind;
		logic               na;
		logic               nb;
		logic               nc;
		logic [MAG_W-1:0]   ma;
		logic [MAG_W-1:0]   mb;
		logic [MAG_W-1:0]   mc;
	} item_t;

	typedef struct packed {
		kind_t kind;
		logic  neg1;
		logic  neg2;
	} dv_tag_t;

endpackage

@@ rtl/core/quadratic_root_solver_top.sv @@
// quadratic_root_solver_top: top level, config register, front classifier, queue and back pipeline
// depends on qrs_pkg, qrs_front, qrs_fifo, qrs_back
//
// usage
// - coefficient channel: drive coef_square/coef_linear/coef_const (signed Q16.16) with push;
//   a transaction completes on a clock edge with push high and full low
// - result channel: while empty is low the oldest result sits on solution_kind, first_root,
//   second_root and overflow; it is taken on an edge with pop high
// - one result per coefficient set, in order; roots are signed Q32.16, saturated with overflow
// - config: apb write of zero_threshold at byte address 0, read back on prdata; pready is
//   always high; write only while no transaction is in flight
// - path: from push to empty going low a set passes the queue, the product and discriminant
//   registers, the 33-stage square root and the numerator register, then the 51-stage
//   divider, one bit per stage, and the result register
// - throughput: one transaction per cycle, sustained while pop keeps up
// - receiver stall: the back pipeline holds in place while a result waits; the four-entry
//   queue keeps taking coefficient sets until it fills, then full rises
// - reset: arst_n clears the queue, every pipeline valid and the result valid;
//   zero_threshold returns to 1
module quadratic_root_solver_top import qrs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	// coefficient channel
	input  logic                         push,
	output logic                         full,
	input  logic signed [DATA_WIDTH-1:0] coef_square,
	input  logic signed [DATA_WIDTH-1:0] coef_linear,
	input  logic signed [DATA_WIDTH-1:0] coef_const,
	// result channel
	output logic                         empty,
	input  logic                         pop,
	output logic [1:0]                   solution_kind,
	output logic signed [ROOT_WIDTH-1:0] first_root,
	output logic signed [ROOT_WIDTH-1:0] second_root,
	output logic                         overflow,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_AW-1:0]            paddr,
	input  logic [APB_DW-1:0]            pwdata,
	output logic [APB_DW-1:0]            prdata,
	output logic                         pready
);

	// zero_threshold register; register index comes from paddr[2]
	logic [THR_W-1:0] thresh_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ZERO_THRESH);
	assign prdata = (paddr[2] == REG_ZERO_THRESH) ? APB_DW'(thresh_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr) begin
			thresh_q <= pwdata[THR_W-1:0];
		end
	end

	// front: sign/magnitude split and classification straight into the queue
	item_t front_item;

	qrs_front u_front (
		.coef_square (coef_square),
		.coef_linear (coef_linear),
		.coef_const  (coef_const),
		.thresh      (thresh_q),
		.item        (front_item)
	);

	// queue decouples the front from the back pipeline stall
	item_t q_item;
	logic  q_empty, q_pop;

	qrs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (front_item),
		.rd     (q_pop),
		.rdata  (q_item),
		.full   (full),
		.empty  (q_empty)
	);

	// back: discriminant, sqrt, division, saturation, result register
	qrs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (!q_empty),
		.in_item       (q_item),
		.in_pop        (q_pop),
		.empty         (empty),
		.pop           (pop),
		.solution_kind (solution_kind),
		.first_root    (first_root),
		.second_root   (second_root),
		.overflow      (overflow)
	);

endmodule

@@ rtl/core/qrs_front.sv @@
// qrs_front: splits coefficients into sign and magnitude and classifies the equation
// depends on qrs_pkg
module qrs_front import qrs_pkg::*; (
	input  logic signed [DATA_WIDTH-1:0] coef_square,
	input  logic signed [DATA_WIDTH-1:0] coef_linear,
	input  logic signed [DATA_WIDTH-1:0] coef_const,
	input  logic [THR_W-1:0]             thresh,
	output item_t                        item
);

	logic [MAG_W-1:0] ma, mb, mc;
	logic za, zb, zc;

	// most negative code maps to 2^(w-1), which still fits unsigned
	assign ma = coef_square[DATA_WIDTH-1] ? MAG_W'(-coef_square) : MAG_W'(coef_square);
	assign mb = coef_linear[DATA_WIDTH-1] ? MAG_W'(-coef_linear) : MAG_W'(coef_linear);
	assign mc = coef_const[DATA_WIDTH-1]  ? MAG_W'(-coef_const)  : MAG_W'(coef_const);

	assign za = (ma == '0) || (ma < MAG_W'(thresh));
	assign zb = (mb == '0) || (mb < MAG_W'(thresh));
	assign zc = (mc == '0) || (mc < MAG_W'(thresh));

	always_comb begin
		item.na = coef_square[DATA_WIDTH-1];
		item.nb = coef_linear[DATA_WIDTH-1];
		item.nc = coef_const[DATA_WIDTH-1];
		item.ma = ma;
		item.mb = mb;
		item.mc = mc;
		priority if (za && zb) begin
			item.kind = zc ? KIND_ANY : KIND_NONE;
		end else if (za) begin
			item.kind = KIND_LINEAR;
		end else begin
			item.kind = KIND_TWO;
		end
	end

endmodule

@@ rtl/core/qrs_fifo.sv @@
// qrs_fifo: short queue of classified items between front and back
// depends on qrs_pkg
module qrs_fifo import qrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wdata,
	input  logic  rd,
	output item_t rdata,
	output logic  full,
	output logic  empty
);

	item_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wptr_q, rptr_q;
	logic [FIFO_AW:0]     cnt_q;
	logic                 do_wr, do_rd;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wdata;
	end

endmodule

@@ rtl/core/qrs_sqrt.sv @@
// qrs_sqrt: pipelined floor square root of the discriminant, one root bit per stage
// depends on qrs_pkg
module qrs_sqrt import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DISC_W-1:0] in_disc,
	input  item_t             in_tag,
	output logic              out_valid,
	output logic [SQRT_W-1:0] out_root,
	output item_t             out_tag
);

	logic [SQRT_W-1:0] vld_s;
	logic [REM_W-1:0]  rem_s  [SQRT_W];
	logic [SQRT_W-1:0] root_s [SQRT_W];
	logic [DISC_W-1:0] dsh_s  [SQRT_W];
	item_t             tag_s  [SQRT_W];

	for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
		logic [REM_W-1:0]  rem_in, remt, trial;
		logic [SQRT_W-1:0] root_in;
		logic [DISC_W-1:0] d_in;
		item_t             t_in;
		logic              v_in, ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign d_in    = in_disc;
			assign t_in    = in_tag;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign d_in    = dsh_s[k-1];
			assign t_in    = tag_s[k-1];
			assign v_in    = vld_s[k-1];
		end

		// bring down the next two bits, try root*4+1
		assign remt  = {rem_in[REM_W-3:0], d_in[DISC_W-1 -: 2]};
		assign trial = REM_W'({root_in, 2'b01});
		assign ge    = (remt >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (remt - trial) : remt;
				root_s[k] <= {root_in[SQRT_W-2:0], ge};
				dsh_s[k]  <= {d_in[DISC_W-3:0], 2'b00};
				tag_s[k]  <= t_in;
			end
		end
	end

	assign out_valid = vld_s[SQRT_W-1];
	assign out_root  = root_s[SQRT_W-1];
	assign out_tag   = tag_s[SQRT_W-1];

endmodule

@@ rtl/core/qrs_div.sv @@
// qrs_div: two-lane pipelined restoring divider, num * 2^FRAC_BITS / den, one quotient bit per stage
// depends on qrs_pkg
module qrs_div import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num1,
	input  logic [NUM_W-1:0]  in_num2,
	input  logic [DEN_W-1:0]  in_den,
	input  dv_tag_t           in_tag,
	output logic              out_valid,
	output logic [DVD_W-1:0]  out_quo1,
	output logic [DVD_W-1:0]  out_quo2,
	output dv_tag_t           out_tag
);

	// dividend bits shift out at the top while quotient bits shift in at the bottom
	function automatic logic [DEN_W+DVD_W-1:0] div_step(input logic [DEN_W-1:0] r,
			input logic [DVD_W-1:0] qd, input logic [DEN_W-1:0] d);
		logic [DEN_W:0] t;
		logic           ge;
		t  = {r, qd[DVD_W-1]};
		ge = (t >= {1'b0, d});
		return {ge ? DEN_W'(t - {1'b0, d}) : DEN_W'(t), qd[DVD_W-2:0], ge};
	endfunction

	logic [DVD_W-1:0] vld_s;
	logic [DEN_W-1:0] rem1_s [DVD_W];
	logic [DEN_W-1:0] rem2_s [DVD_W];
	logic [DVD_W-1:0] qd1_s  [DVD_W];
	logic [DVD_W-1:0] qd2_s  [DVD_W];
	logic [DEN_W-1:0] den_s  [DVD_W];
	dv_tag_t          tag_s  [DVD_W];

	for (genvar k = 0; k < DVD_W; k++) begin : g_stage
		logic [DEN_W-1:0] r1_in, r2_in, d_in;
		logic [DVD_W-1:0] q1_in, q2_in;
		dv_tag_t          t_in;
		logic             v_in;

		if (k == 0) begin : g_first
			assign r1_in = '0;
			assign r2_in = '0;
			assign q1_in = {in_num1, {FRAC_BITS{1'b0}}};
			assign q2_in = {in_num2, {FRAC_BITS{1'b0}}};
			assign d_in  = in_den;
			assign t_in  = in_tag;
			assign v_in  = in_valid;
		end else begin : g_next
			assign r1_in = rem1_s[k-1];
			assign r2_in = rem2_s[k-1];
			assign q1_in = qd1_s[k-1];
			assign q2_in = qd2_s[k-1];
			assign d_in  = den_s[k-1];
			assign t_in  = tag_s[k-1];
			assign v_in  = vld_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				{rem1_s[k], qd1_s[k]} <= div_step(r1_in, q1_in, d_in);
				{rem2_s[k], qd2_s[k]} <= div_step(r2_in, q2_in, d_in);
				den_s[k] <= d_in;
				tag_s[k] <= t_in;
			end
		end
	end

	assign out_valid = vld_s[DVD_W-1];
	assign out_quo1  = qd1_s[DVD_W-1];
	assign out_quo2  = qd2_s[DVD_W-1];
	assign out_tag   = tag_s[DVD_W-1];

endmodule

@@ rtl/core/qrs_back.sv @@
// qrs_back: discriminant, square root, numerators, division, saturation and result register
// depends on qrs_pkg, qrs_sqrt, qrs_div
module qrs_back import qrs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  item_t                       in_item,
	output logic                        in_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  solution_kind,
	output logic signed [ROOT_WIDTH-1:0] first_root,
	output logic signed [ROOT_WIDTH-1:0] second_root,
	output logic                        overflow
);

	localparam logic [DVD_W-1:0] LIM_POS = DVD_W'((64'd1 << (ROOT_WIDTH-1)) - 64'd1);
	localparam logic [DVD_W-1:0] LIM_NEG = DVD_W'(64'd1 << (ROOT_WIDTH-1));

	function automatic logic [ROOT_WIDTH:0] sat_root(input logic [DVD_W-1:0] q, input logic neg);
		logic [DVD_W-1:0]      lim;
		logic                  sat;
		logic [ROOT_WIDTH-1:0] m;
		lim = neg ? LIM_NEG : LIM_POS;
		sat = (q > lim);
		m   = sat ? lim[ROOT_WIDTH-1:0] : q[ROOT_WIDTH-1:0];
		return {sat, neg ? -m : m};
	endfunction

	logic en;
	logic vld_q;

	assign en     = !vld_q || pop;
	assign in_pop = en && in_valid;
	assign empty  = !vld_q;

	// stage 1: products
	logic              vld_s1;
	logic [PROD_W-1:0] bb_s1, p_s1;
	item_t             item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1   <= in_item.mb * in_item.mb;
			p_s1    <= in_item.ma * in_item.mc;
			item_s1 <= in_item;
		end
	end

	// stage 2: discriminant
	logic              vld_s2;
	logic [DISC_W-1:0] disc_s2;
	item_t             item_s2;
	logic [DISC_W-1:0] bbx, p4, dsum;
	logic [DISC_W:0]   ddif;
	logic [DISC_W-1:0] disc_d;
	item_t             item_d;

	assign bbx  = DISC_W'(bb_s1);
	assign p4   = {p_s1, 2'b00};
	assign dsum = bbx + p4;
	assign ddif = {1'b0, bbx} - {1'b0, p4};

	always_comb begin
		item_d = item_s1;
		disc_d = '0;
		if (item_s1.kind == KIND_TWO) begin
			priority if (item_s1.na != item_s1.nc) begin
				disc_d = dsum;
			end else if (ddif[DISC_W]) begin
				item_d.kind = KIND_NONE;
			end else begin
				disc_d = ddif[DISC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s2 <= disc_d;
			item_s2 <= item_d;
		end
	end

	logic              sq_vld;
	logic [SQRT_W-1:0] sq_root;
	item_t             sq_item;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_disc   (disc_s2),
		.in_tag    (item_s2),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_tag   (sq_item)
	);

	// stage 3: numerators and divisor
	logic             vld_s3;
	logic [NUM_W-1:0] num1_s3, num2_s3;
	logic [DEN_W-1:0] den_s3;
	dv_tag_t          tag_s3;
	logic [NUM_W-1:0] mbx, sx, nsum, nadif, n1_d, n2_d;
	logic [DEN_W-1:0] den_d;
	logic             mb_ge, sg1, sg2;
	dv_tag_t          tag_d;

	assign mbx   = NUM_W'(sq_item.mb);
	assign sx    = NUM_W'(sq_root);
	assign nsum  = mbx + sx;
	assign mb_ge = (mbx >= sx);
	assign nadif = mb_ge ? (mbx - sx) : (sx - mbx);

	always_comb begin
		n1_d       = '0;
		n2_d       = '0;
		den_d      = '0;
		tag_d.kind = sq_item.kind;
		tag_d.neg1 = 1'b0;
		tag_d.neg2 = 1'b0;
		sg1        = 1'b0;
		sg2        = 1'b0;
		unique case (sq_item.kind)
			KIND_LINEAR: begin
				n1_d       = NUM_W'(sq_item.mc);
				den_d      = DEN_W'(sq_item.mb);
				tag_d.neg1 = (sq_item.nc == sq_item.nb);
			end
			KIND_TWO: begin
				// -b - s and -b + s in sign and magnitude
				n1_d       = sq_item.nb ? nadif : nsum;
				sg1        = sq_item.nb ? !mb_ge : 1'b1;
				n2_d       = sq_item.nb ? nsum : nadif;
				sg2        = sq_item.nb ? 1'b0 : mb_ge;
				den_d      = {sq_item.ma, 1'b0};
				tag_d.neg1 = (sg1 != sq_item.na);
				tag_d.neg2 = (sg2 != sq_item.na);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s3 <= n1_d;
			num2_s3 <= n2_d;
			den_s3  <= den_d;
			tag_s3  <= tag_d;
		end
	end

	logic             dv_vld;
	logic [DVD_W-1:0] quo1, quo2;
	dv_tag_t          dv_tag;

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_num1   (num1_s3),
		.in_num2   (num2_s3),
		.in_den    (den_s3),
		.in_tag    (tag_s3),
		.out_valid (dv_vld),
		.out_quo1  (quo1),
		.out_quo2  (quo2),
		.out_tag   (dv_tag)
	);

	// saturation and result register
	logic [ROOT_WIDTH:0]   sr1, sr2;
	logic [ROOT_WIDTH-1:0] r1_d, r2_d;
	logic                  ovf_d;
	logic [1:0]            kind_q;
	logic [ROOT_WIDTH-1:0] r1_q, r2_q;
	logic                  ovf_q;

	assign sr1 = sat_root(quo1, dv_tag.neg1);
	assign sr2 = sat_root(quo2, dv_tag.neg2);

	always_comb begin
		r1_d  = '0;
		r2_d  = '0;
		ovf_d = 1'b0;
		unique case (dv_tag.kind)
			KIND_LINEAR: begin
				r1_d  = sr1[ROOT_WIDTH-1:0];
				ovf_d = sr1[ROOT_WIDTH];
			end
			KIND_TWO: begin
				r1_d  = sr1[ROOT_WIDTH-1:0];
				r2_d  = sr2[ROOT_WIDTH-1:0];
				ovf_d = sr1[ROOT_WIDTH] | sr2[ROOT_WIDTH];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= dv_tag.kind;
			r1_q   <= r1_d;
			r2_q   <= r2_d;
			ovf_q  <= ovf_d;
		end
	end

	assign solution_kind = kind_q;
	assign first_root    = r1_q;
	assign second_root   = r2_q;
	assign overflow      = ovf_q;

endmodule

@@ test/quadratic_root_solver_top_tb.sv @@
// quadratic_root_solver_top_tb: self-checking bench for the quadratic root solver
// drives coefficient sets through the push/full side, predicts each result, checks pop/empty side
// depends on qrs_pkg and quadratic_root_solver_top
`timescale 1ns / 100ps

module quadratic_root_solver_top_tb;
	import qrs_pkg::*;

	// one coefficient set and one predicted solution
	typedef struct {
		logic signed [DATA_WIDTH-1:0] a;
		logic signed [DATA_WIDTH-1:0] b;
		logic signed [DATA_WIDTH-1:0] c;
	} coef_set_t;

	typedef struct {
		kind_t                        kind;
		logic signed [ROOT_WIDTH-1:0] r1;
		logic signed [ROOT_WIDTH-1:0] r2;
		logic                         ovf;
	} solution_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [DATA_WIDTH-1:0] coef_square;
	logic signed [DATA_WIDTH-1:0] coef_linear;
	logic signed [DATA_WIDTH-1:0] coef_const;
	logic empty;
	logic pop;
	logic [1:0] solution_kind;
	logic signed [ROOT_WIDTH-1:0] first_root;
	logic signed [ROOT_WIDTH-1:0] second_root;
	logic overflow;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// predictor copy of the threshold register
	logic [THR_W-1:0] zero_thresh_model;

	coef_set_t pending_sets[$];
	solution_t expected_solutions[$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned hold_left;
	int unsigned hold_at;
	logic pop_hold;
	logic quiet;

	quadratic_root_solver_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.coef_square(coef_square),
		.coef_linear(coef_linear),
		.coef_const(coef_const),
		.empty(empty),
		.pop(pop),
		.solution_kind(solution_kind),
		.first_root(first_root),
		.second_root(second_root),
		.overflow(overflow),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// magnitude of a two's complement coefficient; -2^31 gives 2^31
	function automatic logic [MAG_W-1:0] coef_magnitude(input logic signed [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	// sign-magnitude sum of two wide values
	function automatic logic [127:0] sm_sum(input logic nx, input logic [127:0] mx,
			input logic ny, input logic [127:0] my, output logic neg);
		if (nx == ny) begin
			neg = nx;
			return mx + my;
		end
		if (mx >= my) begin
			neg = nx;
			return mx - my;
		end
		neg = ny;
		return my - mx;
	endfunction

	// trunc(num * 2^FRAC_BITS / den) with sign, saturated to the root range
	function automatic logic [ROOT_WIDTH-1:0] fixed_quotient(input logic [127:0] num,
			input logic [127:0] den, input logic neg, inout logic ovf);
		logic [127:0] lim;
		logic [127:0] q;
		lim = (128'd1 << (ROOT_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
		if (den == 0) begin
			q = (num != 0) ? lim : 128'd0;
			if (num != 0)
				ovf = 1'b1;
		end else begin
			q = (num << FRAC_BITS) / den;
			if (q > lim) begin
				q = lim;
				ovf = 1'b1;
			end
		end
		return neg ? ROOT_WIDTH'(-q) : ROOT_WIDTH'(q);
	endfunction

	// floor square root of a non-negative discriminant
	function automatic logic [127:0] disc_sqrt(input logic [127:0] d);
		logic [127:0] s;
		logic [127:0] t;
		s = 0;
		for (int bit_i = 33; bit_i >= 0; bit_i--) begin
			t = s | (128'd1 << bit_i);
			if (t * t <= d)
				s = t;
		end
		return s;
	endfunction

	function automatic solution_t solve_roots(input coef_set_t cs, input logic [THR_W-1:0] thr);
		solution_t sol;
		logic na, nb, nc, za, zb, zc, neg;
		logic [MAG_W-1:0] ma, mb, mc;
		logic [127:0] bb, p4, disc, root, num;
		na = cs.a[DATA_WIDTH-1];
		nb = cs.b[DATA_WIDTH-1];
		nc = cs.c[DATA_WIDTH-1];
		ma = coef_magnitude(cs.a);
		mb = coef_magnitude(cs.b);
		mc = coef_magnitude(cs.c);
		za = (ma == 0) || (ma < thr);
		zb = (mb == 0) || (mb < thr);
		zc = (mc == 0) || (mc < thr);
		sol.r1 = '0;
		sol.r2 = '0;
		sol.ovf = 1'b0;
		if (za && zb) begin
			sol.kind = zc ? KIND_ANY : KIND_NONE;
		end else if (za) begin
			// single root -c/b
			sol.kind = KIND_LINEAR;
			sol.r1 = fixed_quotient(128'(mc), 128'(mb), nc == nb, sol.ovf);
		end else begin
			bb = 128'(mb) * 128'(mb);
			p4 = (128'(ma) * 128'(mc)) << 2;
			if (na == nc && p4 > bb) begin
				sol.kind = KIND_NONE;
			end else begin
				disc = (na != nc) ? bb + p4 : bb - p4;
				root = disc_sqrt(disc);
				num = sm_sum(!nb, 128'(mb), 1'b1, root, neg);
				sol.r1 = fixed_quotient(num, 128'(ma) << 1, neg != na, sol.ovf);
				num = sm_sum(!nb, 128'(mb), 1'b0, root, neg);
				sol.r2 = fixed_quotient(num, 128'(ma) << 1, neg != na, sol.ovf);
				sol.kind = KIND_TWO;
			end
		end
		return sol;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
		error_count++;
	endtask

	// ---------------------------------------------------------------- driver

	// random idling, with odds of 18 in 100 on each call, except in one quiet stretch
	function automatic logic idle_now();
		if (quiet)
			return 1'b0;
		return $urandom_range(99) < 18;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic next_push;
		coef_set_t cs;
		if (!arst_n) begin
			push <= 1'b0;
			coef_square <= '0;
			coef_linear <= '0;
			coef_const <= '0;
		end else begin
			// the set on the ports is taken this edge: predict its solution now
			if (push && !full)
				expected_solutions.push_back(solve_roots('{coef_square, coef_linear, coef_const},
					zero_thresh_model));
			// offer the next set unless the current one is still waiting
			if (push && full) begin
				next_push = 1'b1;
			end else if (pending_sets.size() > 0 && !idle_now()) begin
				cs = pending_sets.pop_front();
				coef_square <= cs.a;
				coef_linear <= cs.b;
				coef_const <= cs.c;
				next_push = 1'b1;
			end else begin
				next_push = 1'b0;
			end
			push <= next_push;
		end
	end

	// ---------------------------------------------------------------- monitor

	// long receiver hold-off, counted here so the queue fills and full rises
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			pop_hold <= 1'b0;
		end else begin
			if (cycle_count == hold_at)
				hold_left <= 400;
			else if (hold_left > 0)
				hold_left <= hold_left - 1;
			pop_hold <= (cycle_count == hold_at) || (hold_left > 1);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		solution_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_solutions.size() == 0) begin
					$display("unexpected result transaction at cycle %0d", cycle_count);
					error_count++;
				end else begin
					want = expected_solutions.pop_front();
					if (solution_kind !== want.kind)
						report_mismatch("solution_kind", 64'(solution_kind), 64'(want.kind));
					if (first_root !== want.r1)
						report_mismatch("first_root", 64'(first_root), 64'(want.r1));
					if (second_root !== want.r2)
						report_mismatch("second_root", 64'(second_root), 64'(want.r2));
					if (overflow !== want.ovf)
						report_mismatch("overflow", 64'(overflow), 64'(want.ovf));
				end
			end
			pop <= !pop_hold && !idle_now();
		end
	end

	// ---------------------------------------------------------------- timeout

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic write_zero_thresh(input logic [THR_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({REG_ZERO_THRESH, 2'b00});
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		zero_thresh_model = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic add_set(input logic signed [DATA_WIDTH-1:0] a,
			input logic signed [DATA_WIDTH-1:0] b, input logic signed [DATA_WIDTH-1:0] c);
		pending_sets.push_back('{a, b, c});
	endtask

	// small coefficient near the threshold, in either sign
	function automatic logic signed [DATA_WIDTH-1:0] near_zero();
		logic [DATA_WIDTH-1:0] m;
		m = DATA_WIDTH'($urandom_range(32'(zero_thresh_model) + 2));
		return $urandom_range(1) ? -$signed(m) : $signed(m);
	endfunction

	// coefficient of moderate size, integer part of a few bits
	function automatic logic signed [DATA_WIDTH-1:0] moderate();
		return $signed($urandom) >>> $urandom_range(8, 20);
	endfunction

	task automatic add_random_sets(input int count);
		logic signed [DATA_WIDTH-1:0] a, b, c;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					a = $signed($urandom);
					b = $signed($urandom);
					c = $signed($urandom);
				end
				3, 4, 5: begin
					a = moderate();
					b = moderate();
					c = moderate();
				end
				6: begin
					a = near_zero();
					b = moderate();
					c = $signed($urandom);
				end
				7: begin
					a = near_zero();
					b = near_zero();
					c = near_zero();
				end
				8: begin
					// tiny leading term gives huge roots
					a = near_zero();
					b = $signed($urandom);
					c = moderate();
				end
				default: begin
					a = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
					b = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
					c = $signed($urandom);
				end
			endcase
			add_set(a, b, c);
		end
	endtask

	// sender pause until every outstanding result has arrived
	task automatic drain();
		while (pending_sets.size() > 0 || push || expected_solutions.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		zero_thresh_model = THRESH_RESET;
		error_count = 0;
		cycle_count = 0;
		hold_at = '1;
		quiet = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed sets at the reset threshold
		add_set(0, 0, 0);
		add_set(0, 0, 32'sh0005_0000);
		add_set(0, 32'sh0002_0000, -32'sh0004_0000);
		add_set(32'sh0001_0000, -32'sh0003_0000, 32'sh0002_0000);
		add_set(32'sh0001_0000, 0, 32'sh0001_0000);
		add_set(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
		add_set(-32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000);
		add_set(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
		add_set(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
		add_set(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
		add_set(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
		add_set(1, 32'sh7fff_ffff, 0);
		add_set(1, 32'sh8000_0000, 32'sh7fff_ffff);
		add_set(0, 1, 32'sh7fff_ffff);
		add_set(0, -1, 32'sh8000_0000);
		add_set(0, 32'sh8000_0000, 32'sh8000_0000);
		add_set(32'sh0001_0000, 32'sh0004_0000, 1);
		add_set(-1, -1, -1);
		add_set(0, 0, 32'sh8000_0000);
		add_set(32'sh0003_0000, 0, 0);
		add_random_sets(320);
		// receiver holds off early in this batch while sets keep coming
		hold_at = cycle_count + 40;
		drain();

		// zero threshold: only exact zeros count as zero
		write_zero_thresh(0);
		add_set(0, 0, 0);
		add_set(0, 1, 1);
		add_set(1, 0, -1);
		add_random_sets(340);
		drain();

		// widest threshold: small constants still feed the discriminant
		// whole batch runs with no idling on either side
		write_zero_thresh(16'hffff);
		quiet = 1'b1;
		add_set(32'sh0000_fffe, 32'sh0000_ffff, 32'sh0000_fffe);
		add_set(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0100);
		add_set(0, 32'sh0001_0000, -32'sh0000_ffff);
		add_random_sets(340);
		drain();
		quiet = 1'b0;

		write_zero_thresh(16'($urandom));
		add_random_sets(340);
		drain();

		write_zero_thresh(16'd1);
		add_random_sets(340);
		drain();

		if (expected_solutions.size() == 0 && error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_fifo.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/qrs_back.sv
rtl/core/quadratic_root_solver_top.sv
test/quadratic_root_solver_top_tb.sv
